// ----- src/kvt_pkg.sv -----
// Shared types and constants for the key/value line tokenizer.
// No dependencies; used by kvt_core, kvt_out_buf and the top level.
package kvt_pkg;

  localparam int unsigned PosBitsDefault = 16;
  localparam logic [15:0] FirstLineReset = 16'd1;

  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;

  typedef enum logic [1:0] {
    StPair      = 2'd0,
    StBadFormat = 2'd1,
    StEndOfData = 2'd2
  } status_e;

  // One report as it leaves the block.
  typedef struct packed {
    status_e     status;
    logic [15:0] key_start;
    logic [15:0] key_length;
    logic [15:0] value_start;
    logic [15:0] value_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } res_t;

endpackage

// ----- src/kvt_core.sv -----
// Tokenizer state and the per-byte update: builds up to two reports per item.
// Depends on kvt_pkg.
module kvt_core #(
  parameter int unsigned PosBits = kvt_pkg::PosBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_data_i,
  output kvt_pkg::res_t       res0_o,
  output kvt_pkg::res_t       res1_o,
  output logic [1:0]          res_cnt_o
);

  localparam logic [PosBits-1:0] PosMax = '1;

  logic [PosBits-1:0] offset_q, offset_d;
  logic [15:0]        line_q, line_d;
  logic [PosBits-1:0] key_begin_q, key_begin_d, key_size_q, key_size_d;
  logic [PosBits-1:0] value_begin_q, value_begin_d, value_size_q, value_size_d;
  logic key_open_q, key_open_d, value_open_q, value_open_d;
  logic key_done_q, key_done_d, value_done_q, value_done_d;
  logic in_comment_q, in_comment_d;

  logic               p_emit;
  kvt_pkg::status_e   p_status;
  logic [PosBits-1:0] p_kb, p_ks, p_vb, p_vs;
  logic [PosBits-1:0] ks_close, vs_close;
  kvt_pkg::res_t      p_res, e_res;

  function automatic logic [15:0] pos16(input logic [PosBits-1:0] x);
    logic [PosBits+15:0] w;
    w = {16'd0, x};
    return w[15:0];
  endfunction

  // Size of a word closed at the current byte.
  assign ks_close = (key_open_q && !key_done_q) ? offset_q - key_begin_q : key_size_q;
  assign vs_close = (value_open_q && !value_done_q) ? offset_q - value_begin_q
                                                    : value_size_q;

  always_comb begin
    offset_d      = offset_q;
    line_d        = line_q;
    key_begin_d   = key_begin_q;
    key_size_d    = key_size_q;
    value_begin_d = value_begin_q;
    value_size_d  = value_size_q;
    key_open_d    = key_open_q;
    value_open_d  = value_open_q;
    key_done_d    = key_done_q;
    value_done_d  = value_done_q;
    in_comment_d  = in_comment_q;
    p_emit        = 1'b0;
    p_status      = kvt_pkg::StPair;
    p_kb          = key_begin_q;
    p_ks          = key_size_q;
    p_vb          = value_begin_q;
    p_vs          = value_size_q;

    if (!(in_comment_q && data_byte_i != kvt_pkg::ChNewline)) begin
      case (data_byte_i)
        kvt_pkg::ChTab, kvt_pkg::ChSpace: begin
          key_size_d   = ks_close;
          key_done_d   = key_open_q;
          value_size_d = vs_close;
          value_done_d = value_open_q;
        end
        kvt_pkg::ChNewline: begin
          in_comment_d = 1'b0;
          value_size_d = vs_close;
          value_done_d = value_open_q;
          if (key_done_q && value_open_q) begin
            p_emit   = 1'b1;
            p_status = kvt_pkg::StPair;
            p_vs     = vs_close;
          end else if (key_open_q && !value_open_q) begin
            p_emit   = 1'b1;
            p_status = kvt_pkg::StBadFormat;
          end
          if (p_emit) begin
            key_begin_d = '0; key_size_d = '0; value_begin_d = '0; value_size_d = '0;
            key_open_d = 1'b0; value_open_d = 1'b0;
            key_done_d = 1'b0; value_done_d = 1'b0;
          end
          line_d = line_q + {15'd0, (line_q != 16'hffff)};
        end
        kvt_pkg::ChHash: begin
          value_size_d = vs_close;
          value_done_d = value_open_q;
          in_comment_d = 1'b1;
        end
        default: begin
          key_open_d = 1'b1;
          if (!key_open_q) key_begin_d = offset_q;
          if (!value_open_q && key_done_q) begin
            value_open_d  = 1'b1;
            value_begin_d = offset_q;
          end
          // third word on the line: report, then restart with this byte as key
          if (key_done_q && value_done_q) begin
            p_emit        = 1'b1;
            p_status      = kvt_pkg::StBadFormat;
            key_begin_d   = offset_q;
            key_size_d    = '0;
            value_begin_d = '0;
            value_size_d  = '0;
            value_open_d  = 1'b0;
            key_done_d    = 1'b0;
            value_done_d  = 1'b0;
            in_comment_d  = 1'b0;
          end
        end
      endcase
    end

    if (end_of_data_i) begin
      key_begin_d = '0; key_size_d = '0; value_begin_d = '0; value_size_d = '0;
      key_open_d = 1'b0; value_open_d = 1'b0;
      key_done_d = 1'b0; value_done_d = 1'b0;
      in_comment_d = 1'b0;
    end

    if (offset_q != PosMax) offset_d = offset_q + {{(PosBits-1){1'b0}}, 1'b1};
  end

  always_comb begin
    p_res.status       = p_status;
    p_res.key_start    = pos16(p_kb);
    p_res.key_length   = pos16(p_ks);
    p_res.value_start  = pos16(p_vb);
    p_res.value_length = pos16(p_vs);
    p_res.line_number  = line_q;
    p_res.last_of_run  = !end_of_data_i;

    e_res.status       = kvt_pkg::StEndOfData;
    e_res.key_start    = '0;
    e_res.key_length   = '0;
    e_res.value_start  = '0;
    e_res.value_length = '0;
    e_res.line_number  = line_d;
    e_res.last_of_run  = 1'b1;

    res0_o    = p_emit ? p_res : e_res;
    res1_o    = e_res;
    res_cnt_o = {1'b0, p_emit} + {1'b0, end_of_data_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      line_q        <= kvt_pkg::FirstLineReset;
      key_begin_q   <= '0;
      key_size_q    <= '0;
      value_begin_q <= '0;
      value_size_q  <= '0;
      key_open_q    <= 1'b0;
      value_open_q  <= 1'b0;
      key_done_q    <= 1'b0;
      value_done_q  <= 1'b0;
      in_comment_q  <= 1'b0;
    end else if (cfg_we_i) begin
      line_q <= cfg_wdata_i;
    end else if (in_fire_i) begin
      offset_q      <= offset_d;
      line_q        <= line_d;
      key_begin_q   <= key_begin_d;
      key_size_q    <= key_size_d;
      value_begin_q <= value_begin_d;
      value_size_q  <= value_size_d;
      key_open_q    <= key_open_d;
      value_open_q  <= value_open_d;
      key_done_q    <= key_done_d;
      value_done_q  <= value_done_d;
      in_comment_q  <= in_comment_d;
    end
  end

endmodule

// ----- src/kvt_out_buf.sv -----
// Two-entry result register: holds the reports of one item for the output side.
// Depends on kvt_pkg.
module kvt_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [1:0]    res_cnt_i,
  input  kvt_pkg::res_t res0_i,
  input  kvt_pkg::res_t res1_i,
  output logic          space_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output kvt_pkg::res_t m_res_o
);

  kvt_pkg::res_t head_q, head_d, tail_q, tail_d;
  logic [1:0]    count_q, count_d;
  logic          pop;

  assign pop       = (count_q != 2'd0) && m_ready_i;
  assign space_o   = (count_q == 2'd0) || ((count_q == 2'd1) && m_ready_i);
  assign m_valid_o = (count_q != 2'd0);
  assign m_res_o   = head_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop) begin
      head_d  = tail_q;
      count_d = count_q - 2'd1;
    end
    // a push only happens when the buffer is empty after this cycle's pop
    if (push_i) begin
      if (res_cnt_i != 2'd0) head_d = res0_i;
      tail_d  = res1_i;
      count_d = res_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("result buffer count out of range");

  a_push_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && res_cnt_i == 2'd2) |=> count_q == 2'd2)
    else $error("two reports not both held");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !m_ready_i) |=> (count_q == 2'd2 && $stable(head_q)))
    else $error("full buffer changed while stalled");

  a_full_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && m_ready_i) |=> count_q == 2'd1)
    else $error("full buffer did not drain by one");

endmodule

// ----- src/key_value_line_tokenizer.sv -----
// Top level of the key/value line tokenizer: stream ports around core and buffer.
// Depends on kvt_pkg, kvt_core and kvt_out_buf.
//
// One byte is taken per clock while there is space. Each byte updates the
// tokenizer state in the same cycle and its reports (none, one or two) land in a
// two-entry result register, so the first report of a byte appears on the master
// side the cycle after it. A byte that raises two reports (a line report plus the
// end-of-data report) fills both entries; the slave side is ready while that
// register is empty, or holds one report that is being taken. tuser carries
// the status, tlast marks the last report of a byte. A cfg write reloads the
// line counter with the first line number and should only be made while idle.
module key_value_line_tokenizer #(
  parameter int unsigned POSITION_BITS = kvt_pkg::PosBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,   // first_line
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // end_of_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] key_start, [31:16] key_length, [47:32] value_start,
  // [63:48] value_length, [79:64] line_number
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast   // last_of_run
);

  logic          in_fire;
  logic          space;
  logic [1:0]    res_cnt;
  kvt_pkg::res_t res0, res1, m_res;

  assign s_axis_tready = space;
  assign in_fire       = s_axis_tvalid && space;

  kvt_core #(
    .PosBits (POSITION_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_fire_i     (in_fire),
    .data_byte_i   (s_axis_tdata),
    .end_of_data_i (s_axis_tlast),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  kvt_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_fire),
    .res_cnt_i (res_cnt),
    .res0_i    (res0),
    .res1_i    (res1),
    .space_o   (space),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata = {m_res.line_number, m_res.value_length, m_res.value_start,
                         m_res.key_length, m_res.key_start};
  assign m_axis_tuser = m_res.status;
  assign m_axis_tlast = m_res.last_of_run;

endmodule
